// ===== hw/rtl/ezr_pkg.sv =====
// Package for the ZXZ Euler angle to orientation matrix block.
// Holds the payload structs, the CORDIC arctangent table and the element formatting.
// Depends on nothing; every other file of the block but ezr_round_mul uses it.
`timescale 1ns / 1ps

package ezr_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int ELEMENT_BITS  = 16;
    localparam int CORDIC_STAGES = 30;
    localparam int LANES         = 3;
    localparam int ANGLE_SHIFT   = 32 - ANGLE_BITS;

    // Gain of the rotation sequence, Q2.30.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Element formatting: Q2.30 sum down to Q1.(ELEMENT_BITS-1).
    localparam int OUT_SHIFT = 31 - ELEMENT_BITS;
    localparam int SHIFT_POS = (OUT_SHIFT > 0) ? OUT_SHIFT : 0;
    localparam int ROUND_POS = (OUT_SHIFT > 0) ? OUT_SHIFT - 1 : 0;
    localparam logic signed [34:0] EL_MAX = (35'sd1 <<< (ELEMENT_BITS - 1)) - 35'sd1;
    localparam logic signed [34:0] EL_MIN = -(35'sd1 <<< (ELEMENT_BITS - 1));

    typedef logic signed [ELEMENT_BITS-1:0] element_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_first;
        logic [ANGLE_BITS-1:0] angle_middle;
        logic [ANGLE_BITS-1:0] angle_last;
    } angles_t;

    typedef struct packed {
        element_t m00;
        element_t m01;
        element_t m02;
        element_t m10;
        element_t m11;
        element_t m12;
        element_t m20;
        element_t m21;
        element_t m22;
    } matrix_t;

    // State carried from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               neg;
    } cordic_t;

    function automatic element_t to_element(input logic signed [32:0] v);
        logic signed [34:0] w;
        logic signed [34:0] r;
        w = {{2{v[32]}}, v};
        if (OUT_SHIFT > 0)
        begin
            r = (w + (35'sd1 <<< ROUND_POS)) >>> SHIFT_POS;
        end
        else if (OUT_SHIFT == 0)
        begin
            r = w;
        end
        else
        begin
            r = w <<< 1;
        end
        if (r > EL_MAX)
        begin
            r = EL_MAX;
        end
        else if (r < EL_MIN)
        begin
            r = EL_MIN;
        end
        return r[ELEMENT_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/ezr_cordic_cell.sv =====
// One rotation step of the sine/cosine CORDIC chain, with its own stage register.
// Depends on ezr_pkg for the cell state struct and the arctangent table.
`timescale 1ns / 1ps

module ezr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              en,
    input  ezr_pkg::cordic_t  prev,
    output ezr_pkg::cordic_t  cur
);

    ezr_pkg::cordic_t   data_reg;
    ezr_pkg::cordic_t   data_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] step;

    assign dx   = prev.y >>> STAGE;
    assign dy   = prev.x >>> STAGE;
    assign step = $signed(ezr_pkg::ATAN_TURNS[STAGE]);

    always_comb
    begin
        data_next.neg = prev.neg;
        if (!prev.z[31])
        begin
            data_next.x = prev.x - dx;
            data_next.y = prev.y + dy;
            data_next.z = prev.z - step;
        end
        else
        begin
            data_next.x = prev.x + dx;
            data_next.y = prev.y - dy;
            data_next.z = prev.z + step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign cur = data_reg;

endmodule

// ===== hw/rtl/ezr_round_mul.sv =====
// Registered Q2.30 by Q2.30 product, rounded half up back to Q2.30.
// Depends on nothing but the timescale.
`timescale 1ns / 1ps

module ezr_round_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] p
);

    logic signed [63:0] prod;
    logic signed [63:0] rounded;
    logic signed [31:0] p_reg;

    assign prod    = a * b;
    assign rounded = prod + 64'sd536870912;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= rounded[61:30];
        end
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/euler_zxz_to_rotation_matrix_top.sv =====
// Top level of the ZXZ Euler angle to orientation matrix block.
// Depends on ezr_pkg, ezr_cordic_cell and ezr_round_mul.
`timescale 1ns / 1ps

// Usage
// The angle channel (angle_valid, angle_stall, angle_data) takes one triple of
// binary angles phi1, Phi, phi2 per transaction; a full turn is 2^ANGLE_BITS.
// The matrix channel (matrix_valid, matrix_stall, matrix_data) returns the nine
// Q1.15 elements of the orientation matrix, one transaction per input, in order.
// Throughput is one transaction per cycle while angle_stall is low. Each angle runs
// through a chain of 30 CORDIC cells, then a sign stage, two multiply stages, a sum
// stage and a format stage, and from there into the output register.
// The output register is backed by a one-entry skid register. When the receiver
// stalls, one more result lands in the skid register; then angle_stall rises and
// the whole pipeline holds until the receiver takes the waiting result.
// Reset clears every valid bit, including those of the output and skid registers;
// the data registers keep their contents. The block takes input in the first
// cycle after reset is released.

module euler_zxz_to_rotation_matrix_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             angle_valid,
    output logic             angle_stall,
    input  ezr_pkg::angles_t angle_data,
    output logic             matrix_valid,
    input  logic             matrix_stall,
    output ezr_pkg::matrix_t matrix_data
);

    localparam int NSTAGE     = ezr_pkg::CORDIC_STAGES;
    localparam int PIPE_DEPTH = NSTAGE + 5;

    logic                  en;
    logic [PIPE_DEPTH-1:0] pipe_vld_reg;
    logic [PIPE_DEPTH-1:0] pipe_vld_next;

    logic [ezr_pkg::ANGLE_BITS-1:0] lane_angle [ezr_pkg::LANES];
    ezr_pkg::cordic_t               fold_in    [ezr_pkg::LANES];
    ezr_pkg::cordic_t               chain      [ezr_pkg::LANES][NSTAGE];

    logic signed [31:0] cos_reg [ezr_pkg::LANES];
    logic signed [31:0] sin_reg [ezr_pkg::LANES];

    // First multiply stage outputs and operands carried to the second.
    logic signed [31:0] p_c1c3, p_c2s1, p_c3s1, p_c1c2, p_s2s3, p_c1s3;
    logic signed [31:0] p_c2c3, p_s1s3, p_c3s2, p_s1s2, p_c1s2;
    logic signed [31:0] d1_s3_reg, d1_s1_reg, d1_c3_reg, d1_c2_reg;

    // Second multiply stage outputs and the pairwise products carried along.
    logic signed [31:0] q_c2s1s3, q_c1c2s3, q_c2c3s1, q_c1c2c3;
    logic signed [31:0] d2_c1c3_reg, d2_c3s1_reg, d2_s2s3_reg, d2_c1s3_reg;
    logic signed [31:0] d2_s1s3_reg, d2_c3s2_reg, d2_s1s2_reg, d2_c1s2_reg;
    logic signed [31:0] d2_c2_reg;

    logic signed [32:0] sum_reg [9];
    logic signed [32:0] sum_next [9];

    ezr_pkg::matrix_t fmt_reg;
    ezr_pkg::matrix_t out_reg;
    ezr_pkg::matrix_t skid_reg;
    logic             out_vld_reg;
    logic             skid_vld_reg;
    logic             take;
    logic             deliver;

    // The pipeline moves as long as the skid register is free.
    assign en          = !skid_vld_reg;
    assign angle_stall = skid_vld_reg;
    assign take        = out_vld_reg && !matrix_stall;
    assign deliver     = en && pipe_vld_reg[PIPE_DEPTH-1];

    assign pipe_vld_next = {pipe_vld_reg[PIPE_DEPTH-2:0], angle_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
        end
        else if (en)
        begin
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    assign lane_angle[0] = angle_data.angle_first;
    assign lane_angle[1] = angle_data.angle_middle;
    assign lane_angle[2] = angle_data.angle_last;

    genvar gl, gs;
    generate
        for (gl = 0; gl < ezr_pkg::LANES; gl++)
        begin : g_lane
            logic [31:0] a32;
            logic        fold;

            // Angles in the left half plane are turned by half a turn and the
            // results negated after the chain.
            assign a32  = 32'(lane_angle[gl]) << ezr_pkg::ANGLE_SHIFT;
            assign fold = a32[31] ^ a32[30];
            assign fold_in[gl].x   = ezr_pkg::CORDIC_GAIN;
            assign fold_in[gl].y   = '0;
            assign fold_in[gl].z   = $signed({a32[31] ^ fold, a32[30:0]});
            assign fold_in[gl].neg = fold;

            for (gs = 0; gs < NSTAGE; gs++)
            begin : g_cell
                if (gs == 0)
                begin : g_first
                    ezr_cordic_cell #(.STAGE(gs)) u_cell (
                        .clk  (clk),
                        .en   (en),
                        .prev (fold_in[gl]),
                        .cur  (chain[gl][gs])
                    );
                end
                else
                begin : g_next
                    ezr_cordic_cell #(.STAGE(gs)) u_cell (
                        .clk  (clk),
                        .en   (en),
                        .prev (chain[gl][gs-1]),
                        .cur  (chain[gl][gs])
                    );
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cos_reg[gl] <= chain[gl][NSTAGE-1].neg ? -chain[gl][NSTAGE-1].x
                                                           : chain[gl][NSTAGE-1].x;
                    sin_reg[gl] <= chain[gl][NSTAGE-1].neg ? -chain[gl][NSTAGE-1].y
                                                           : chain[gl][NSTAGE-1].y;
                end
            end
        end
    endgenerate

    // First multiply stage.
    ezr_round_mul u_c1c3 (.clk(clk), .en(en), .a(cos_reg[0]), .b(cos_reg[2]), .p(p_c1c3));
    ezr_round_mul u_c2s1 (.clk(clk), .en(en), .a(cos_reg[1]), .b(sin_reg[0]), .p(p_c2s1));
    ezr_round_mul u_c3s1 (.clk(clk), .en(en), .a(cos_reg[2]), .b(sin_reg[0]), .p(p_c3s1));
    ezr_round_mul u_c1c2 (.clk(clk), .en(en), .a(cos_reg[0]), .b(cos_reg[1]), .p(p_c1c2));
    ezr_round_mul u_s2s3 (.clk(clk), .en(en), .a(sin_reg[1]), .b(sin_reg[2]), .p(p_s2s3));
    ezr_round_mul u_c1s3 (.clk(clk), .en(en), .a(cos_reg[0]), .b(sin_reg[2]), .p(p_c1s3));
    ezr_round_mul u_c2c3 (.clk(clk), .en(en), .a(cos_reg[1]), .b(cos_reg[2]), .p(p_c2c3));
    ezr_round_mul u_s1s3 (.clk(clk), .en(en), .a(sin_reg[0]), .b(sin_reg[2]), .p(p_s1s3));
    ezr_round_mul u_c3s2 (.clk(clk), .en(en), .a(cos_reg[2]), .b(sin_reg[1]), .p(p_c3s2));
    ezr_round_mul u_s1s2 (.clk(clk), .en(en), .a(sin_reg[0]), .b(sin_reg[1]), .p(p_s1s2));
    ezr_round_mul u_c1s2 (.clk(clk), .en(en), .a(cos_reg[0]), .b(sin_reg[1]), .p(p_c1s2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_s3_reg <= sin_reg[2];
            d1_s1_reg <= sin_reg[0];
            d1_c3_reg <= cos_reg[2];
            d1_c2_reg <= cos_reg[1];
        end
    end

    // Second multiply stage for the triple products.
    ezr_round_mul u_c2s1s3 (.clk(clk), .en(en), .a(p_c2s1), .b(d1_s3_reg), .p(q_c2s1s3));
    ezr_round_mul u_c1c2s3 (.clk(clk), .en(en), .a(p_c1c2), .b(d1_s3_reg), .p(q_c1c2s3));
    ezr_round_mul u_c2c3s1 (.clk(clk), .en(en), .a(p_c2c3), .b(d1_s1_reg), .p(q_c2c3s1));
    ezr_round_mul u_c1c2c3 (.clk(clk), .en(en), .a(p_c1c2), .b(d1_c3_reg), .p(q_c1c2c3));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_c1c3_reg <= p_c1c3;
            d2_c3s1_reg <= p_c3s1;
            d2_s2s3_reg <= p_s2s3;
            d2_c1s3_reg <= p_c1s3;
            d2_s1s3_reg <= p_s1s3;
            d2_c3s2_reg <= p_c3s2;
            d2_s1s2_reg <= p_s1s2;
            d2_c1s2_reg <= p_c1s2;
            d2_c2_reg   <= d1_c2_reg;
        end
    end

    always_comb
    begin
        sum_next[0] = 33'(d2_c1c3_reg) - 33'(q_c2s1s3);
        sum_next[1] = 33'(d2_c3s1_reg) + 33'(q_c1c2s3);
        sum_next[2] = 33'(d2_s2s3_reg);
        sum_next[3] = -33'(d2_c1s3_reg) - 33'(q_c2c3s1);
        sum_next[4] = 33'(q_c1c2c3) - 33'(d2_s1s3_reg);
        sum_next[5] = 33'(d2_c3s2_reg);
        sum_next[6] = 33'(d2_s1s2_reg);
        sum_next[7] = -33'(d2_c1s2_reg);
        sum_next[8] = 33'(d2_c2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fmt_reg.m00 <= ezr_pkg::to_element(sum_reg[0]);
            fmt_reg.m01 <= ezr_pkg::to_element(sum_reg[1]);
            fmt_reg.m02 <= ezr_pkg::to_element(sum_reg[2]);
            fmt_reg.m10 <= ezr_pkg::to_element(sum_reg[3]);
            fmt_reg.m11 <= ezr_pkg::to_element(sum_reg[4]);
            fmt_reg.m12 <= ezr_pkg::to_element(sum_reg[5]);
            fmt_reg.m20 <= ezr_pkg::to_element(sum_reg[6]);
            fmt_reg.m21 <= ezr_pkg::to_element(sum_reg[7]);
            fmt_reg.m22 <= ezr_pkg::to_element(sum_reg[8]);
        end
    end

    // Output register with a one-entry skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (deliver)
        begin
            if (!out_vld_reg || take)
            begin
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (deliver)
        begin
            if (!out_vld_reg || take)
            begin
                out_reg <= fmt_reg;
            end
            else
            begin
                skid_reg <= fmt_reg;
            end
        end
    end

    assign matrix_valid = out_vld_reg;
    assign matrix_data  = out_reg;

endmodule

// ===== hw/rtl/ezr_checker.sv =====
// Port-level checks for the Euler angle to orientation matrix block, bound to its top level.
// Depends on ezr_pkg and euler_zxz_to_rotation_matrix_top.
`timescale 1ns / 1ps

module ezr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             angle_stall,
    input logic             matrix_valid,
    input logic             matrix_stall,
    input ezr_pkg::matrix_t matrix_data
);

    // A result waiting under stall keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid && matrix_stall |=> matrix_valid && $stable(matrix_data))
    else $error("matrix transaction changed while stalled");

    // The input side is held back only while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> matrix_valid)
    else $error("angle channel stalled with no result pending");

    // The skid register fills only when the receiver refused a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(angle_stall) |-> $past(matrix_valid && matrix_stall))
    else $error("angle channel stalled without a refused result");

    // Once the receiver takes the result, the input side is free again.
    assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall && !matrix_stall |=> !angle_stall)
    else $error("angle channel stayed stalled after a result was taken");

endmodule

bind euler_zxz_to_rotation_matrix_top ezr_checker u_ezr_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the ZXZ Euler angle to orientation matrix block.
// Predicts each matrix with its own CORDIC and fixed-point arithmetic and checks every field.
// Depends on ezr_pkg and euler_zxz_to_rotation_matrix_top.
`timescale 1ns / 1ps

module tb;

    typedef logic [ezr_pkg::ANGLE_BITS-1:0] angle_word_t;

    localparam int  STAGES      = 30;
    localparam int  FMT_SHIFT   = 31 - ezr_pkg::ELEMENT_BITS;
    localparam int  FMT_ROUND   = (FMT_SHIFT > 0) ? FMT_SHIFT - 1 : 0;
    localparam int  FMT_RSHIFT  = (FMT_SHIFT > 0) ? FMT_SHIFT : 0;
    localparam int  LONG_HOLD   = 400;
    localparam int  TAIL_CYCLES = 60;
    localparam int  CYCLE_LIMIT = 500000;
    localparam longint GAIN_Q30 = 652032874;

    // Arctangent of 2^-i, in units of 2^-32 of a turn.
    localparam longint ARCTAN_STEP [STAGES] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             angle_valid  = 1'b0;
    logic             angle_stall;
    ezr_pkg::angles_t angle_data   = '0;
    logic             matrix_valid;
    logic             matrix_stall = 1'b1;
    ezr_pkg::matrix_t matrix_data;

    ezr_pkg::angles_t angle_pending [$];
    ezr_pkg::matrix_t matrix_expect [$];

    int  error_count   = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  cycle_count   = 0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    bit  idle_enable   = 1'b0;
    bit  hold_request  = 1'b0;
    logic hold_served  = 1'b0;

    euler_zxz_to_rotation_matrix_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angle_data   (angle_data),
        .matrix_valid (matrix_valid),
        .matrix_stall (matrix_stall),
        .matrix_data  (matrix_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cosine and sine of a binary angle, both in Q2.30.
    function automatic void cordic_sincos(input angle_word_t ang, output longint c,
                                          output longint s);
        logic [31:0] u;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        u = 32'(ang) << (32 - ezr_pkg::ANGLE_BITS);
        // The two middle quadrants are turned by half a turn and negated at the end.
        flip = u[31] ^ u[30];
        if (flip)
        begin
            u = u + 32'h80000000;
        end
        z = longint'(signed'(u));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic ezr_pkg::element_t format_element(input longint v);
        longint r;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (ezr_pkg::ELEMENT_BITS - 1)) - 1;
        lo = -hi - 1;
        if (FMT_SHIFT > 0)
        begin
            r = (v + (longint'(1) <<< FMT_ROUND)) >>> FMT_RSHIFT;
        end
        else if (FMT_SHIFT == 0)
        begin
            r = v;
        end
        else
        begin
            r = v * 2;
        end
        if (r > hi)
        begin
            r = hi;
        end
        if (r < lo)
        begin
            r = lo;
        end
        return r[ezr_pkg::ELEMENT_BITS-1:0];
    endfunction

    function automatic ezr_pkg::matrix_t predict_matrix(input ezr_pkg::angles_t a);
        ezr_pkg::matrix_t m;
        longint  c1;
        longint  s1;
        longint  c2;
        longint  s2;
        longint  c3;
        longint  s3;
        cordic_sincos(a.angle_first, c1, s1);
        cordic_sincos(a.angle_middle, c2, s2);
        cordic_sincos(a.angle_last, c3, s3);
        m.m00 = format_element(qmul(c1, c3) - qmul(qmul(c2, s1), s3));
        m.m01 = format_element(qmul(c3, s1) + qmul(qmul(c1, c2), s3));
        m.m02 = format_element(qmul(s2, s3));
        m.m10 = format_element(-qmul(c1, s3) - qmul(qmul(c2, c3), s1));
        m.m11 = format_element(qmul(qmul(c1, c2), c3) - qmul(s1, s3));
        m.m12 = format_element(qmul(c3, s2));
        m.m20 = format_element(qmul(s1, s2));
        m.m21 = format_element(-qmul(c1, s2));
        m.m22 = format_element(c2);
        return m;
    endfunction

    task automatic check_matrix(input ezr_pkg::matrix_t got);
        ezr_pkg::matrix_t  want;
        ezr_pkg::element_t w;
        ezr_pkg::element_t g;
        string    names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
        if (matrix_expect.size() == 0)
        begin
            $error("matrix transaction arrived with none expected");
            error_count++;
            return;
        end
        want = matrix_expect.pop_front();
        checked_count++;
        for (int k = 0; k < 9; k++)
        begin
            w = want[(8 - k) * ezr_pkg::ELEMENT_BITS +: ezr_pkg::ELEMENT_BITS];
            g = got[(8 - k) * ezr_pkg::ELEMENT_BITS +: ezr_pkg::ELEMENT_BITS];
            if (g !== w)
            begin
                $error("%s: expected %0d, actual %0d", names[k], w, g);
                error_count++;
            end
        end
    endtask

    // Mostly uniform angles, with a share placed right around the quadrant edges.
    function automatic angle_word_t random_angle();
        angle_word_t q;
        case ($urandom_range(0, 7))
            0, 1:
            begin
                q = angle_word_t'($urandom_range(0, 3)) << (ezr_pkg::ANGLE_BITS - 2);
                return q + angle_word_t'($urandom_range(0, 8)) - angle_word_t'(4);
            end
            2:
            begin
                return ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
            default:
            begin
                return angle_word_t'($urandom);
            end
        endcase
    endfunction

    task automatic queue_random(input int count);
        ezr_pkg::angles_t a;
        for (int n = 0; n < count; n++)
        begin
            a.angle_first  = random_angle();
            a.angle_middle = random_angle();
            a.angle_last   = random_angle();
            angle_pending.push_back(a);
        end
    endtask

    task automatic wait_drained();
        while (angle_pending.size() != 0 || angle_valid || matrix_expect.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sender: holds a stalled transaction, otherwise offers the next angles or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid <= 1'b0;
            angle_data  <= '0;
            gap_left     = 0;
        end
        else
        begin
            if (angle_valid && !angle_stall)
            begin
                matrix_expect.push_back(predict_matrix(angle_data));
                sent_count++;
            end
            if (!(angle_valid && angle_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    angle_valid <= 1'b0;
                end
                else if (idle_enable && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(1, 11) - 1;
                    angle_valid <= 1'b0;
                end
                else if (angle_pending.size() != 0)
                begin
                    angle_data  <= angle_pending.pop_front();
                    angle_valid <= 1'b1;
                end
                else
                begin
                    angle_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each matrix transaction and drives the stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_stall <= 1'b1;
            hold_served  <= 1'b0;
            stall_left    = 0;
            hold_left     = 0;
        end
        else
        begin
            if (matrix_valid && !matrix_stall)
            begin
                check_matrix(matrix_data);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                matrix_stall <= 1'b1;
            end
            else if (hold_request && !hold_served)
            begin
                hold_left = LONG_HOLD - 1;
                hold_served  <= 1'b1;
                matrix_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                matrix_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                matrix_stall <= 1'b1;
            end
            else
            begin
                matrix_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        ezr_pkg::angles_t edge_cases [17] = '{
            '{16'h0000, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'h4000, 16'h4000, 16'h4000}, '{16'h8000, 16'h8000, 16'h8000},
            '{16'hC000, 16'hC000, 16'hC000}, '{16'h3FFF, 16'h4001, 16'hBFFF},
            '{16'hC001, 16'h7FFF, 16'h8001}, '{16'h0000, 16'h4000, 16'h0000},
            '{16'h4000, 16'h0000, 16'hC000}, '{16'h2000, 16'h6000, 16'hA000},
            '{16'hE000, 16'h0001, 16'hFFFE}, '{16'h5555, 16'hAAAA, 16'h0000},
            '{16'hAAAA, 16'h5555, 16'hFFFF}, '{16'h0000, 16'h8000, 16'h0000},
            '{16'h8000, 16'h0000, 16'h8000}, '{16'h1234, 16'h8765, 16'hFEDC},
            '{16'h0001, 16'h0002, 16'h0004}
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners: zero angles give the identity, so the diagonal saturates.
        idle_enable = 1'b1;
        foreach (edge_cases[k])
        begin
            angle_pending.push_back(edge_cases[k]);
        end
        wait_drained();

        // The receiver holds off for a long stretch while the sender keeps offering.
        queue_random(200);
        hold_request = 1'b1;
        wait_drained();

        queue_random(380);

        // Last part: full rate on both sides.
        while (angle_pending.size() > 100)
        begin
            @(negedge clk);
        end
        idle_enable = 1'b0;
        queue_random(100);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d angle triples and checked %0d matrices, with directed corners,",
                 sent_count, checked_count);
        $display("quadrant-edge angles, random idling and a long receiver hold-off.");
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
